>>> hw/rtl/snsf_pkg.sv
`default_nettype none
package snsf_pkg;

	localparam int SMP_W = 24;
	localparam int CHANNELS = 2;
	localparam int GAIN_W = 16;
	localparam int COEF_W = 24;
	localparam int GAIN_FRAC = 12;
	localparam int COEF_FRAC = 21;

	// Wide enough for any product plus rounding in the lanes.
	localparam int WIDE_W = 2 * SMP_W + 4;
	localparam int FB_W = COEF_W + 1;
	localparam int GPROD_W = SMP_W + 1 + GAIN_W;
	localparam int CPROD_W = SMP_W + FB_W;
	localparam int IDX_W = 2;

	localparam logic signed [COEF_W-1:0] B0_RESET = COEF_W'(1) <<< COEF_FRAC;

	localparam logic signed [WIDE_W-1:0] SAT_HI = (WIDE_W'(1) <<< (SMP_W - 1)) - WIDE_W'(1);
	localparam logic signed [WIDE_W-1:0] SAT_LO = -(WIDE_W'(1) <<< (SMP_W - 1));

	typedef enum logic [IDX_W-1:0] {
		REG_GAIN = 2'd0,
		REG_B0   = 2'd1,
		REG_B1   = 2'd2,
		REG_A1   = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic signed [SMP_W-1:0] left_in;
		logic signed [SMP_W-1:0] right_in;
		logic                    last_in;
	} frame_in_t;

	typedef struct packed {
		logic signed [SMP_W-1:0] left_out;
		logic signed [SMP_W-1:0] right_out;
		logic                    last_out;
	} frame_out_t;

	typedef struct packed {
		logic accept;
		logic load2;
		logic load3;
		logic adv;
	} lane_ctl_t;

	function automatic logic signed [WIDE_W-1:0] rnd_shift(
		input logic signed [WIDE_W-1:0] v,
		input int unsigned n
	);
		logic signed [WIDE_W-1:0] half;
		half = WIDE_W'(1) <<< (n - 1);
		return (v + half) >>> n;
	endfunction

	function automatic logic signed [SMP_W-1:0] sat_smp(input logic signed [WIDE_W-1:0] v);
		logic signed [SMP_W-1:0] r;
		if (v > SAT_HI) begin
			r = SAT_HI[SMP_W-1:0];
		end else if (v < SAT_LO) begin
			r = SAT_LO[SMP_W-1:0];
		end else begin
			r = v[SMP_W-1:0];
		end
		return r;
	endfunction

endpackage
`default_nettype wire

>>> hw/rtl/snsf_lane.sv
`default_nettype none
module snsf_lane (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire snsf_pkg::lane_ctl_t                    ctl,
	input  wire logic signed [snsf_pkg::SMP_W-1:0]      x,
	input  wire logic signed [snsf_pkg::GAIN_W-1:0]     gain,
	input  wire logic signed [snsf_pkg::COEF_W-1:0]     b0,
	input  wire logic signed [snsf_pkg::FB_W-1:0]       fb,
	output logic signed [snsf_pkg::SMP_W-1:0]           y
);
	import snsf_pkg::*;

	logic signed [SMP_W-1:0]   prev_q;
	logic signed [SMP_W-1:0]   state_q;
	logic signed [SMP_W:0]     diff;
	logic signed [GPROD_W-1:0] gprod_s1;
	logic signed [SMP_W-1:0]   x_s1;
	logic signed [SMP_W-1:0]   e_s2;
	logic signed [CPROD_W-1:0] pb0_s3;
	logic signed [CPROD_W-1:0] pfb_s3;
	logic signed [SMP_W-1:0]   state_nxt;

	assign diff = (SMP_W + 1)'(x) - (SMP_W + 1)'(prev_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q  <= '0;
			state_q <= '0;
		end else begin
			if (ctl.accept) begin
				prev_q <= x;
			end
			if (ctl.adv) begin
				state_q <= state_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			gprod_s1 <= GPROD_W'(diff) * GPROD_W'(gain);
			x_s1     <= x;
		end
		if (ctl.load2) begin
			e_s2 <= sat_smp(WIDE_W'(x_s1) + rnd_shift(WIDE_W'(gprod_s1), GAIN_FRAC));
		end
		if (ctl.load3) begin
			pb0_s3 <= CPROD_W'(e_s2) * CPROD_W'(b0);
			pfb_s3 <= CPROD_W'(e_s2) * CPROD_W'(fb);
		end
	end

	// The stored term depends only on the emphasized input, never on y.
	assign y         = sat_smp(WIDE_W'(state_q) + rnd_shift(WIDE_W'(pb0_s3), COEF_FRAC));
	assign state_nxt = sat_smp(rnd_shift(WIDE_W'(pfb_s3), COEF_FRAC));

endmodule
`default_nettype wire

>>> hw/rtl/stereo_noise_sharpening_filter.sv
// Stereo noise-sharpening filter.
// Input channel in_valid/in_ready/in_data carries one stereo frame per transfer;
// output channel out_valid/out_ready/out_data returns one filtered frame per input.
// Each channel runs in its own lane: emphasis multiply, saturate, then the two
// section multiplies; the output register merges the lanes and the last flag.
// out_valid rises once the frame has passed the three lane stages and the output
// register. One frame is in flight in the lanes at a time, so a new frame is taken
// only once the previous one has left the third lane stage. A new frame may be
// accepted while the previous result still waits in the output register.
// If the receiver stalls, the finished frame waits in the third lane stage and
// in_ready stays low until the output register frees.
// Configuration: cfg_we writes cfg_data into register cfg_index
// (0 gain, 1 b0, 2 b1, 3 a1); write only while no frame is in flight.
// Reset clears the per-channel history and stored section terms, and loads
// gain 0, b0 1.0, b1 0 and a1 0.
`default_nettype none
module stereo_noise_sharpening_filter (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire snsf_pkg::frame_in_t               in_data,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output snsf_pkg::frame_out_t                   out_data,
	input  wire logic                              cfg_we,
	input  wire logic [snsf_pkg::IDX_W-1:0]        cfg_index,
	input  wire logic [snsf_pkg::COEF_W-1:0]       cfg_data
);
	import snsf_pkg::*;

	logic signed [GAIN_W-1:0] gain_q;
	logic signed [COEF_W-1:0] b0_q;
	logic signed [COEF_W-1:0] b1_q;
	logic signed [COEF_W-1:0] a1_q;
	logic signed [FB_W-1:0]   fb;

	logic       vld_s1, vld_s2, vld_s3;
	logic       last_s1, last_s2, last_s3;
	logic       out_valid_q;
	frame_out_t out_q;
	lane_ctl_t  ctl;
	logic       in_xfer;

	logic signed [SMP_W-1:0] lane_x [CHANNELS];
	logic signed [SMP_W-1:0] lane_y [CHANNELS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= '0;
			b0_q   <= B0_RESET;
			b1_q   <= '0;
			a1_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_GAIN: gain_q <= cfg_data[GAIN_W-1:0];
				REG_B0:   b0_q   <= cfg_data;
				REG_B1:   b1_q   <= cfg_data;
				REG_A1:   a1_q   <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign fb = FB_W'(a1_q) + FB_W'(b1_q);

	assign in_ready  = !vld_s1 && !vld_s2 && !vld_s3;
	assign in_xfer   = in_valid && in_ready;
	assign ctl.accept = in_xfer;
	assign ctl.load2  = vld_s1;
	assign ctl.load3  = vld_s2;
	assign ctl.adv    = vld_s3 && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1      <= 1'b0;
			vld_s2      <= 1'b0;
			vld_s3      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			vld_s1 <= in_xfer;
			vld_s2 <= vld_s1;
			if (vld_s2) begin
				vld_s3 <= 1'b1;
			end else if (ctl.adv) begin
				vld_s3 <= 1'b0;
			end
			if (ctl.adv) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			last_s1 <= in_data.last_in;
		end
		if (vld_s1) begin
			last_s2 <= last_s1;
		end
		if (vld_s2) begin
			last_s3 <= last_s2;
		end
		if (ctl.adv) begin
			out_q.left_out  <= lane_y[0];
			out_q.right_out <= lane_y[1];
			out_q.last_out  <= last_s3;
		end
	end

	assign lane_x[0] = in_data.left_in;
	assign lane_x[1] = in_data.right_in;

	for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
		snsf_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl),
			.x      (lane_x[c]),
			.gain   (gain_q),
			.b0     (b0_q),
			.fb     (fb),
			.y      (lane_y[c])
		);
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

`ifndef SYNTHESIS
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({vld_s1, vld_s2, vld_s3}))
		else $error("more than one frame in the lane pipeline");

	a_s1_to_s2: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |=> vld_s2)
		else $error("frame lost between first and second stage");

	a_s2_to_s3: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 |=> vld_s3)
		else $error("frame lost between second and third stage");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s3 && out_valid_q && !out_ready |=> vld_s3 && out_valid_q)
		else $error("finished frame dropped while output stalled");

	a_adv_fills_out: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.adv |=> out_valid_q && !vld_s3)
		else $error("merge did not load the output register");
`endif

endmodule
`default_nettype wire

>>> sim/snsf_checker.sv
`default_nettype none
module snsf_checker (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	input  wire logic                        in_ready,
	input  wire snsf_pkg::frame_in_t         in_data,
	input  wire logic                        out_valid,
	input  wire logic                        out_ready,
	input  wire snsf_pkg::frame_out_t        out_data,
	input  wire logic                        cfg_we,
	input  wire logic [snsf_pkg::IDX_W-1:0]  cfg_index,
	input  wire logic [snsf_pkg::COEF_W-1:0] cfg_data,
	output int                               mismatches,
	output int                               outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	import snsf_pkg::*;

	localparam int REPORT_LIMIT = 10;

	logic signed [GAIN_W-1:0] gain_q;
	logic signed [COEF_W-1:0] b0_q;
	logic signed [COEF_W-1:0] b1_q;
	logic signed [COEF_W-1:0] a1_q;

	logic signed [SMP_W-1:0] prev_sample [CHANNELS];
	logic signed [SMP_W-1:0] stored_term [CHANNELS];

	frame_out_t expected_frames [$];
	int fail_total;

	// Add half an LSB and floor; the arithmetic shift on a signed longint floors.
	function automatic longint round_frac(input longint v, input int n);
		return (v + (longint'(1) <<< (n - 1))) >>> n;
	endfunction

	function automatic logic signed [SMP_W-1:0] clamp_sample(input longint v);
		longint hi;
		longint lo;
		hi = (longint'(1) <<< (SMP_W - 1)) - 1;
		lo = -(longint'(1) <<< (SMP_W - 1));
		if (v > hi) begin
			return hi[SMP_W-1:0];
		end else if (v < lo) begin
			return lo[SMP_W-1:0];
		end
		return v[SMP_W-1:0];
	endfunction

	// Emphasis, then the first-order section; the stored term is fed from the
	// emphasized input only, never from the output.
	task automatic filter_frame(input frame_in_t f, output frame_out_t r);
		logic signed [SMP_W-1:0] lane_in [CHANNELS];
		logic signed [SMP_W-1:0] lane_out [CHANNELS];
		longint x;
		longint g;
		longint b0;
		longint fb;
		longint e;
		lane_in[0] = f.left_in;
		lane_in[1] = f.right_in;
		g = gain_q;
		b0 = b0_q;
		fb = longint'(a1_q) + longint'(b1_q);
		for (int c = 0; c < CHANNELS; c++) begin
			x = lane_in[c];
			e = clamp_sample(x + round_frac((x - prev_sample[c]) * g, GAIN_FRAC));
			lane_out[c] = clamp_sample(stored_term[c] + round_frac(e * b0, COEF_FRAC));
			stored_term[c] = clamp_sample(round_frac(e * fb, COEF_FRAC));
			prev_sample[c] = x;
		end
		r.left_out = lane_out[0];
		r.right_out = lane_out[1];
		r.last_out = f.last_in;
	endtask

	always @(posedge clk or negedge arst_n) begin
		frame_out_t want;
		if (!arst_n) begin
			gain_q = '0;
			b0_q = B0_RESET;
			b1_q = '0;
			a1_q = '0;
			for (int c = 0; c < CHANNELS; c++) begin
				prev_sample[c] = '0;
				stored_term[c] = '0;
			end
			expected_frames.delete();
			fail_total = 0;
			mismatches <= 0;
			outstanding <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_index))
					REG_GAIN: gain_q = cfg_data[GAIN_W-1:0];
					REG_B0:   b0_q = cfg_data;
					REG_B1:   b1_q = cfg_data;
					REG_A1:   a1_q = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				filter_frame(in_data, want);
				expected_frames.push_back(want);
			end
			if (out_valid && out_ready) begin
				if (expected_frames.size() == 0) begin
					if (fail_total < REPORT_LIMIT) begin
						$display("unexpected output transfer: left %0d right %0d last %0b",
							out_data.left_out, out_data.right_out, out_data.last_out);
					end
					fail_total++;
				end else begin
					want = expected_frames.pop_front();
					if (out_data.left_out !== want.left_out
							|| out_data.right_out !== want.right_out
							|| out_data.last_out !== want.last_out) begin
						if (fail_total < REPORT_LIMIT) begin
							$display("mismatch at %0t: left exp %0d got %0d, right exp %0d got %0d, last exp %0b got %0b",
								$realtime, want.left_out, out_data.left_out,
								want.right_out, out_data.right_out,
								want.last_out, out_data.last_out);
						end
						fail_total++;
					end
				end
			end
			outstanding <= expected_frames.size();
			mismatches <= fail_total;
		end
	end

endmodule
`default_nettype wire

>>> sim/stereo_noise_sharpening_filter_test.sv
`default_nettype none
module stereo_noise_sharpening_filter_test;
	timeunit 1ns;
	timeprecision 1ps;

	import snsf_pkg::*;

	localparam int RAND_PHASES = 6;
	localparam int FRAMES_PER_PHASE = 150;
	localparam int CALM_PHASE = 3;
	localparam int IDLE_PERCENT = 33;
	localparam int STALL_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 8;

	localparam logic signed [SMP_W-1:0] SMP_MAX = {1'b0, {(SMP_W-1){1'b1}}};
	localparam logic signed [SMP_W-1:0] SMP_MIN = {1'b1, {(SMP_W-1){1'b0}}};
	localparam logic signed [GAIN_W-1:0] GAIN_MAX = {1'b0, {(GAIN_W-1){1'b1}}};
	localparam logic signed [GAIN_W-1:0] GAIN_MIN = {1'b1, {(GAIN_W-1){1'b0}}};
	localparam logic signed [COEF_W-1:0] COEF_MAX = {1'b0, {(COEF_W-1){1'b1}}};
	localparam logic signed [COEF_W-1:0] COEF_MIN = {1'b1, {(COEF_W-1){1'b0}}};

	logic              clk;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	frame_in_t         in_data = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	frame_out_t        out_data;
	logic              cfg_we = 1'b0;
	logic [IDX_W-1:0]  cfg_index = '0;
	logic [COEF_W-1:0] cfg_data = '0;
	logic              calm = 1'b0;

	int mismatches;
	int outstanding;
	int quiet_cycles = 0;

	stereo_noise_sharpening_filter dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	snsf_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.mismatches(mismatches),
		.outstanding(outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PERCENT);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
				quiet_cycles <= 0;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("status: fail");
				$finish;
			end
		end
	end

	function automatic frame_in_t make_frame(
		input logic signed [SMP_W-1:0] left,
		input logic signed [SMP_W-1:0] right,
		input logic                    last
	);
		frame_in_t f;
		f.left_in = left;
		f.right_in = right;
		f.last_in = last;
		return f;
	endfunction

	function automatic logic signed [SMP_W-1:0] pick_sample();
		logic signed [SMP_W-1:0] s;
		case ($urandom_range(0, 9))
			0: s = SMP_MAX;
			1: s = SMP_MIN;
			2, 3: s = SMP_W'($urandom_range(0, 511)) - SMP_W'(256);
			default: s = SMP_W'($urandom);
		endcase
		return s;
	endfunction

	// Full range or scaled down by up to three bits, so the section does not always saturate.
	function automatic logic signed [COEF_W-1:0] pick_coef();
		logic signed [COEF_W-1:0] k;
		k = COEF_W'($urandom);
		return k >>> $urandom_range(0, 3);
	endfunction

	// Holds the frame until the transfer; valid stays high for the caller.
	task automatic send_frame(input frame_in_t f);
		in_valid <= 1'b1;
		in_data <= f;
		@(posedge clk);
		while (!in_ready) begin
			@(posedge clk);
		end
	endtask

	task automatic idle_sender();
		while (!calm && $urandom_range(0, 99) < IDLE_PERCENT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
	endtask

	// The first edge lets the checker's count catch up with the last transfer.
	task automatic drain_outputs();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// The gain register is 16 bits; the upper data bits are random and must be ignored.
	task automatic load_coefs(
		input logic [GAIN_W-1:0] gain,
		input logic [COEF_W-1:0] b0,
		input logic [COEF_W-1:0] b1,
		input logic [COEF_W-1:0] a1
	);
		cfg_we <= 1'b1;
		cfg_index <= REG_GAIN;
		cfg_data <= {(COEF_W-GAIN_W)'($urandom), gain};
		@(posedge clk);
		cfg_index <= REG_B0;
		cfg_data <= b0;
		@(posedge clk);
		cfg_index <= REG_B1;
		cfg_data <= b1;
		@(posedge clk);
		cfg_index <= REG_A1;
		cfg_data <= a1;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Reset settings: unity direct path, no emphasis, no stored term.
		send_frame(make_frame(SMP_MAX, SMP_MIN, 1'b1));
		send_frame(make_frame(SMP_MIN, SMP_MAX, 1'b0));
		send_frame(make_frame('0, '0, 1'b1));
		send_frame(make_frame(-1, 1, 1'b0));
		drain_outputs();

		// Largest coefficients: emphasis, output and stored term all hit the rails.
		load_coefs(GAIN_MAX, COEF_MAX, COEF_MAX, COEF_MAX);
		send_frame(make_frame(SMP_MAX, SMP_MIN, 1'b0));
		send_frame(make_frame(SMP_MIN, SMP_MAX, 1'b1));
		send_frame(make_frame(SMP_MAX, SMP_MAX, 1'b0));
		send_frame(make_frame('0, '0, 1'b0));
		send_frame(make_frame(1, -1, 1'b1));
		send_frame(make_frame('0, '0, 1'b0));
		drain_outputs();

		load_coefs(GAIN_MIN, COEF_MIN, COEF_MIN, COEF_MIN);
		send_frame(make_frame(SMP_MIN, SMP_MAX, 1'b1));
		send_frame(make_frame(SMP_MAX, SMP_MIN, 1'b0));
		send_frame(make_frame(SMP_MIN, SMP_MIN, 1'b0));
		send_frame(make_frame('0, '0, 1'b1));
		send_frame(make_frame(-1, 1, 1'b0));
		drain_outputs();

		// Half-LSB rounding ties: gain 0.5 on mostly odd differences, b0 and b1 0.5, a1 -0.25.
		load_coefs(GAIN_W'(2048), COEF_W'(1 << 20), COEF_W'(1 << 20), -COEF_W'(1 << 19));
		send_frame(make_frame(1, -1, 1'b0));
		send_frame(make_frame(-2, 2, 1'b0));
		send_frame(make_frame(3, -3, 1'b1));
		send_frame(make_frame('0, '0, 1'b0));

		for (int p = 0; p < RAND_PHASES; p++) begin
			drain_outputs();
			case (p)
				0: load_coefs(GAIN_W'(4096), COEF_W'(1 << 21), COEF_W'(1 << 20),
					-COEF_W'(1 << 19));
				1: load_coefs(GAIN_W'($urandom) >>> 2, pick_coef(), pick_coef(), pick_coef());
				2: load_coefs(GAIN_MAX, COEF_MAX, COEF_MAX, COEF_MAX);
				4: load_coefs(GAIN_MIN, COEF_MIN, COEF_MIN, COEF_MIN);
				default: load_coefs(GAIN_W'($urandom), pick_coef(), pick_coef(), pick_coef());
			endcase
			calm <= (p == CALM_PHASE);
			for (int i = 0; i < FRAMES_PER_PHASE; i++) begin
				idle_sender();
				send_frame(make_frame(pick_sample(), pick_sample(), $urandom_range(0, 7) == 0));
			end
		end
		drain_outputs();

		if (mismatches == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
`default_nettype wire
